[src/polyphase_rational_resampler_top_macros.svh]
// Assertion macros for the polyphase rational resampler.
// Included by the top level; every macro expects aclk and aresetn in scope.
`ifndef POLYPHASE_RATIONAL_RESAMPLER_TOP_MACROS_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/prr_pkg.sv]
// Shared types and constants of the polyphase rational resampler.
// No dependencies; imported by prr_mac, prr_ctrl and the top level.
package prr_pkg;

    // Fixed field widths of the stream and configuration items.
    localparam int SAMPLE_W     = 16;
    localparam int KIND_W       = 2;
    localparam int COEF_INDEX_W = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int UP_W         = 3;
    localparam int DOWN_W       = 3;
    localparam int TAPS_W       = 7;
    localparam int PC_W         = 2;

    // Coefficients carry three integer bits; the rest is fraction.
    localparam int COEF_INT_BITS = 3;

    // Largest decimation factor and output saturation limits.
    localparam int MAX_DOWN = 4;
    localparam int SAT_MAX  = 32767;
    localparam int SAT_MIN  = -32768;

    // Configuration register reset values.
    localparam logic [UP_W-1:0]   UP_RESET   = 3'd1;
    localparam logic [DOWN_W-1:0] DOWN_RESET = 3'd1;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd48;

    // Item kinds carried in the input tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_COEF   = 2'd1,
        KIND_FLUSH  = 2'd2
    } prr_kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_UP_FACTOR      = 2'd0,
        REG_DOWN_FACTOR    = 2'd1,
        REG_TAPS_PER_PHASE = 2'd2
    } prr_reg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } prr_state_t;

    // Tap issue flags that travel down the multiply-accumulate pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } prr_mac_ctl_t;

    // Strobes from the sequencer to the memories and the output register.
    typedef struct packed {
        logic hist_we;
        logic coef_we;
        logic out_load;
        logic out_last;
    } prr_cmd_t;

endpackage

[src/prr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the sample history and the coefficient store.
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/prr_mac.sv]
// Multiply-accumulate datapath: one tap product per cycle, exact sum, round and saturate.
// Depends on prr_pkg for the pipeline flag struct and output limits.
module prr_mac import prr_pkg::*; #(
    parameter int MAX_TAPS  = 64,
    parameter int COEF_BITS = 18
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  prr_mac_ctl_t                ctl,
    input  logic signed [COEF_BITS-1:0] coef_q,
    input  logic signed [SAMPLE_W-1:0]  hist_q,
    output logic [SAMPLE_W-1:0]         result,
    output logic                        done
);

    localparam int PROD_W    = COEF_BITS + SAMPLE_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS + 1);
    localparam int FRAC_BITS = COEF_BITS - COEF_INT_BITS;

    prr_mac_ctl_t             s1_reg;
    prr_mac_ctl_t             s2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  quo;

    // Flags pass through s1_reg while the memory is read and s2_reg while the product is formed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            s1_reg   <= ctl;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    // The first tap of a phase restarts the sum.
    always_comb begin
        if (s2_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef_q * hist_q;
        if (s2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // Add half an LSB, floor by arithmetic shift, then clip to 16 bits.
    always_comb begin
        rnd = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
        quo = rnd >>> FRAC_BITS;
        if (quo > SAT_MAX) begin
            result = SAMPLE_W'(SAT_MAX);
        end else if (quo < SAT_MIN) begin
            result = SAMPLE_W'(SAT_MIN);
        end else begin
            result = SAMPLE_W'(quo);
        end
    end

    assign done = done_reg;

endmodule

[src/prr_ctrl.sv]
// Sequencer: history pointer and valid bits, phase counter, tap address generation.
// Depends on prr_pkg for item kinds, states and the command structs.
module prr_ctrl import prr_pkg::*; #(
    parameter int MAX_TAPS = 64,
    parameter int MAX_UP   = 4,
    localparam int HP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int CA_W = (MAX_UP * MAX_TAPS > 1) ? $clog2(MAX_UP * MAX_TAPS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_acc,
    input  prr_kind_t         in_kind,
    input  logic [UP_W-1:0]   up_factor,
    input  logic [DOWN_W-1:0] down_factor,
    input  logic [TAPS_W-1:0] taps_per_phase,
    input  logic              out_free,
    input  logic              mac_done,
    output logic              in_ready,
    output prr_cmd_t          cmd,
    output prr_mac_ctl_t      mac_ctl,
    output logic [HP_W-1:0]   hist_waddr,
    output logic [HP_W-1:0]   hist_raddr,
    output logic              hist_vld_q,
    output logic [CA_W-1:0]   coef_raddr
);

    localparam int KW   = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;
    localparam int LW   = $clog2(MAX_UP + 1);
    localparam int TC_W = $clog2(MAX_TAPS + 1);

    prr_state_t          state_reg, state_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [HP_W-1:0]     wp_reg, wp_next;
    logic [MAX_TAPS-1:0] hvld_reg, hvld_next;
    logic [TC_W-1:0]     j_reg, j_next;
    logic [HP_W-1:0]     haddr_reg, haddr_next;
    logic [CA_W-1:0]     caddr_reg, caddr_next;
    logic                last_reg, last_next;
    logic                hvld_q_reg;

    logic [LW-1:0]       l_val;
    logic [DOWN_W-1:0]   m_val;
    logic [TC_W-1:0]     p_val;
    logic [DOWN_W-1:0]   pc_inc;
    logic [DOWN_W-1:0]   pc_wrap;
    logic [DOWN_W-1:0]   t_dist;
    logic [LW-1:0]       r_left;
    logic                emit_last;
    logic                last_phase;
    logic                tap_last;
    logic [HP_W-1:0]     wp_inc;
    logic [HP_W-1:0]     haddr_dec;

    // Out-of-range factors are clamped where they are used.
    always_comb begin
        if (up_factor == '0) begin
            l_val = LW'(1);
        end else if (32'(up_factor) > MAX_UP) begin
            l_val = LW'(MAX_UP);
        end else begin
            l_val = LW'(up_factor);
        end
        if (down_factor == '0) begin
            m_val = DOWN_W'(1);
        end else if (32'(down_factor) > MAX_DOWN) begin
            m_val = DOWN_W'(MAX_DOWN);
        end else begin
            m_val = down_factor;
        end
        if (taps_per_phase == '0) begin
            p_val = TC_W'(1);
        end else if (32'(taps_per_phase) > MAX_TAPS) begin
            p_val = TC_W'(MAX_TAPS);
        end else begin
            p_val = TC_W'(taps_per_phase);
        end
    end

    // Phase counter step, and whether a later phase of this item still emits.
    // After the step the counter is below M, so it reaches zero in M minus
    // its value phases; the current output is the last one if that is too late.
    always_comb begin
        pc_inc     = {1'b0, pc_reg} + DOWN_W'(1);
        pc_wrap    = (pc_inc >= m_val) ? '0 : pc_inc;
        t_dist     = (pc_wrap == '0) ? '0 : m_val - pc_wrap;
        r_left     = l_val - LW'(1) - LW'(k_reg);
        emit_last  = (32'(t_dist) >= 32'(r_left));
        last_phase = (32'(k_reg) == 32'(l_val) - 1);
        tap_last   = (32'(j_reg) == 32'(p_val) - 1);
        wp_inc     = (wp_reg == HP_W'(MAX_TAPS - 1)) ? '0 : wp_reg + HP_W'(1);
        haddr_dec  = (haddr_reg == '0) ? HP_W'(MAX_TAPS - 1) : haddr_reg - HP_W'(1);
    end

    // Next state and outputs.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        pc_next    = pc_reg;
        wp_next    = wp_reg;
        hvld_next  = hvld_reg;
        j_next     = j_reg;
        haddr_next = haddr_reg;
        caddr_next = caddr_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        mac_ctl    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_acc) begin
                    unique case (in_kind)
                        KIND_SAMPLE: begin
                            cmd.hist_we       = 1'b1;
                            wp_next           = wp_inc;
                            hvld_next[wp_inc] = 1'b1;
                            k_next            = '0;
                            state_next        = ST_PHASE;
                        end
                        KIND_COEF: begin
                            cmd.coef_we = 1'b1;
                        end
                        KIND_FLUSH: begin
                            hvld_next = '0;
                            wp_next   = '0;
                            pc_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PHASE: begin
                pc_next = PC_W'(pc_wrap);
                if (pc_reg == '0) begin
                    last_next  = emit_last;
                    j_next     = '0;
                    haddr_next = wp_reg;
                    caddr_next = CA_W'(k_reg);
                    state_next = ST_MAC;
                end else if (last_phase) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_MAC: begin
                // One tap per cycle: newest sample first, coefficient stride L.
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (j_reg == '0);
                mac_ctl.last  = tap_last;
                j_next        = j_reg + TC_W'(1);
                haddr_next    = haddr_dec;
                caddr_next    = caddr_reg + CA_W'(l_val);
                if (tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = last_reg;
                    if (last_phase) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        state_next = ST_PHASE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            pc_reg    <= '0;
            wp_reg    <= '0;
            hvld_reg  <= '0;
            j_reg     <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            pc_reg    <= pc_next;
            wp_reg    <= wp_next;
            hvld_reg  <= hvld_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
        end
    end

    // Addresses and the valid bit read out alongside the history memory.
    always_ff @(posedge aclk) begin
        haddr_reg  <= haddr_next;
        caddr_reg  <= caddr_next;
        hvld_q_reg <= hvld_reg[haddr_reg];
    end

    assign hist_waddr = wp_inc;
    assign hist_raddr = haddr_reg;
    assign coef_raddr = caddr_reg;
    assign hist_vld_q = hvld_q_reg;

endmodule

[src/polyphase_rational_resampler_top.sv]
// Top level of the polyphase rational resampler: ports, configuration, memories, output.
// Depends on prr_pkg, prr_ram, prr_mac, prr_ctrl and the assertion macro header.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid / s_tready  sample, coefficient write or flush item
//   m_*       out        m_tvalid / m_tready  resampled sample, tlast on final of item
//   cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// A coefficient write or flush item is accepted in the idle state. A sample item
// runs L phases; each of the E phases that emit issues its P taps, drains and
// emits. The single multiplier takes one tap per cycle from the coefficient memory.
// Reset (aresetn low at a clock edge) clears the history valid bits and the counters at once.
// A full output register stalls the sequencer only when the next result is ready.
`include "polyphase_rational_resampler_top_macros.svh"

module polyphase_rational_resampler_top import prr_pkg::*; #(
    parameter int MAX_TAPS  = 64,
    parameter int MAX_UP    = 4,
    parameter int COEF_BITS = 18,
    localparam int S_DATA_W = ((SAMPLE_W + COEF_INDEX_W + COEF_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: sample_value [15:0], coef_index [23:16], coef_value, zero fill
    input  logic [S_DATA_W-1:0]    s_tdata,
    // s_tuser: kind
    input  logic [KIND_W-1:0]      s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m_tdata: out_sample
    output logic [SAMPLE_W-1:0]    m_tdata,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int COEF_DEPTH = MAX_UP * MAX_TAPS;
    localparam int HP_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CA_W       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int IDX_SPAN   = 1 << COEF_INDEX_W;
    localparam int CV_LO      = SAMPLE_W + COEF_INDEX_W;

    logic [UP_W-1:0]      up_factor_reg;
    logic [DOWN_W-1:0]    down_factor_reg;
    logic [TAPS_W-1:0]    taps_per_phase_reg;
    logic                 in_acc;
    prr_cmd_t             cmd;
    prr_mac_ctl_t         mac_ctl;
    logic [HP_W-1:0]      hist_waddr;
    logic [HP_W-1:0]      hist_raddr;
    logic                 hist_vld_q;
    logic [CA_W-1:0]      coef_raddr;
    logic [CA_W-1:0]      coef_wmap [IDX_SPAN];
    logic [SAMPLE_W-1:0]  ring_q;
    logic [SAMPLE_W-1:0]  hist_data;
    logic [COEF_BITS-1:0] coef_q;
    logic [SAMPLE_W-1:0]  mac_result;
    logic                 mac_done;
    logic                 out_free;
    logic                 m_tvalid_reg;
    logic [SAMPLE_W-1:0]  m_tdata_reg;
    logic                 m_tlast_reg;

    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_factor_reg      <= UP_RESET;
            down_factor_reg    <= DOWN_RESET;
            taps_per_phase_reg <= TAPS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (prr_reg_t'(cfg_addr))
                REG_UP_FACTOR:      up_factor_reg      <= cfg_wdata[UP_W-1:0];
                REG_DOWN_FACTOR:    down_factor_reg    <= cfg_wdata[DOWN_W-1:0];
                REG_TAPS_PER_PHASE: taps_per_phase_reg <= cfg_wdata[TAPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Coefficient write address: the index folded into the store depth.
    for (genvar g = 0; g < IDX_SPAN; g++) begin : g_wmap
        assign coef_wmap[g] = CA_W'(g % COEF_DEPTH);
    end

    prr_ctrl #(
        .MAX_TAPS (MAX_TAPS),
        .MAX_UP   (MAX_UP)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_acc         (in_acc),
        .in_kind        (prr_kind_t'(s_tuser)),
        .up_factor      (up_factor_reg),
        .down_factor    (down_factor_reg),
        .taps_per_phase (taps_per_phase_reg),
        .out_free       (out_free),
        .mac_done       (mac_done),
        .in_ready       (s_tready),
        .cmd            (cmd),
        .mac_ctl        (mac_ctl),
        .hist_waddr     (hist_waddr),
        .hist_raddr     (hist_raddr),
        .hist_vld_q     (hist_vld_q),
        .coef_raddr     (coef_raddr)
    );

    // Sample history ring.
    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (cmd.hist_we),
        .waddr (hist_waddr),
        .wdata (s_tdata[SAMPLE_W-1:0]),
        .raddr (hist_raddr),
        .rdata (ring_q)
    );

    // Coefficient store, phase-interleaved.
    prr_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (cmd.coef_we),
        .waddr (coef_wmap[s_tdata[CV_LO-1:SAMPLE_W]]),
        .wdata (s_tdata[CV_LO +: COEF_BITS]),
        .raddr (coef_raddr),
        .rdata (coef_q)
    );

    // Entries not written since reset or flush read as zero.
    assign hist_data = hist_vld_q ? ring_q : '0;

    prr_mac #(
        .MAX_TAPS  (MAX_TAPS),
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef_q  (coef_q),
        .hist_q  (hist_data),
        .result  (mac_result),
        .done    (mac_done)
    );

    // Output register.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= mac_result;
            m_tlast_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A held result is never overwritten before it is taken.
    `PRR_ASSERT_SAME(a_out_no_overwrite, cmd.out_load, (!m_tvalid || m_tready), "result overwritten")
    // A sample item keeps the input closed while its phases run.
    `PRR_ASSERT_NEXT(a_sample_busy, (in_acc && s_tuser == KIND_SAMPLE), !s_tready, "input reopened early")
    // The accumulator finishes only inside the work of a sample item.
    `PRR_ASSERT_SAME(a_done_in_work, mac_done, !s_tready, "accumulation done while idle")

endmodule
